FILE: design/iclr_pkg.sv
// Package for the input current limit ramp block.
// Holds the shared codes, widths and channel structs. No dependencies.
package iclr_pkg;

    // Field widths
    localparam int PORT_W    = 4;
    localparam int SUP_W     = 4;
    localparam int LIMIT_W   = 13;
    localparam int TIME_W    = 32;
    localparam int WAIT_W    = 2;
    localparam int STATE_W   = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    // Port code for "no port attached"
    localparam logic [PORT_W-1:0] PORT_NONE = 4'd15;

    // Limit arithmetic
    localparam logic [LIMIT_W-1:0] STEP_MA   = 13'd64;
    localparam logic [LIMIT_W-1:0] SETTLE_MA = 13'd128;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 13'd8191;

    // Reset value of the recovery window register
    localparam logic [TIME_W-1:0] RECOVER_RESET = 32'd1000000;

    // Transaction types
    localparam logic REQ_PORT_CHANGE = 1'b0;
    localparam logic REQ_STEP        = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER  = 1'd1;

    // Wait codes
    localparam logic [WAIT_W-1:0] WAIT_NONE = 2'd0;
    localparam logic [WAIT_W-1:0] WAIT_1S   = 2'd1;
    localparam logic [WAIT_W-1:0] WAIT_2S   = 2'd2;
    localparam logic [WAIT_W-1:0] WAIT_5S   = 2'd3;

    // Ramp state codes as seen on the result channel
    localparam logic [STATE_W-1:0] RS_DISC    = 3'd0;
    localparam logic [STATE_W-1:0] RS_DETECT  = 3'd1;
    localparam logic [STATE_W-1:0] RS_OCCHECK = 3'd2;
    localparam logic [STATE_W-1:0] RS_RAMP    = 3'd3;
    localparam logic [STATE_W-1:0] RS_STABLE  = 3'd4;

    // One result item
    typedef struct packed {
        logic [LIMIT_W-1:0] limit_ma;
        logic [WAIT_W-1:0]  wait_code;
        logic [STATE_W-1:0] ramp_state;
    } iclr_result_t;

    // Controls and live values from the step machine to the history ring
    typedef struct packed {
        logic               log_en;
        logic               rec_en;
        logic [PORT_W-1:0]  live_port;
        logic [SUP_W-1:0]   live_supplier;
        logic [LIMIT_W-1:0] live_limit;
    } iclr_hist_ctrl_t;

endpackage

FILE: design/iclr_in_if.sv
// Request channel of the input current limit ramp block.
// Valid/ready handshake with the request fields. Depends on iclr_pkg.
interface iclr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [iclr_pkg::PORT_W-1:0] port_id;
    logic [iclr_pkg::TIME_W-1:0] now_us;
    logic                        full_charging;
    logic                        vbus_sagging;
    logic [iclr_pkg::SUP_W-1:0]  supplier_now;

    modport source (
        output valid, req_type, port_id, now_us, full_charging, vbus_sagging, supplier_now,
        input  ready
    );
    modport sink (
        input  valid, req_type, port_id, now_us, full_charging, vbus_sagging, supplier_now,
        output ready
    );
endinterface

FILE: design/iclr_out_if.sv
// Result channel of the input current limit ramp block.
// Valid/ready handshake with the result fields. Depends on iclr_pkg.
interface iclr_out_if;
    logic                         valid;
    logic                         ready;
    logic [iclr_pkg::LIMIT_W-1:0] limit_ma;
    logic [iclr_pkg::WAIT_W-1:0]  wait_code;
    logic [iclr_pkg::STATE_W-1:0] ramp_state;

    modport source (
        output valid, limit_ma, wait_code, ramp_state,
        input  ready
    );
    modport sink (
        input  valid, limit_ma, wait_code, ramp_state,
        output ready
    );
endinterface

FILE: design/input_current_limit_ramp.sv
// Top level of the input current limit ramp block.
// Depends on iclr_pkg, iclr_in_if, iclr_out_if, iclr_history and iclr_step.
//
// Usage:
//   in_ch carries requests: a port change (req_type 0) or a ramp step
//   (req_type 1). A port change logs the previous port into the event
//   ring and returns nothing; a step returns one item on out_ch with the
//   limit to apply, the wait code and the new ramp state.
//   cfg_we/cfg_index/cfg_data write the baseline limit (index 0) and the
//   recovery window in us (index 1); write only while the block is idle.
// Timing:
//   A transaction lands in the input register, passes the step machine
//   and its result is registered in the output register, from which
//   out_ch takes it. One transaction per cycle sustained while out_ch
//   does not stall; the step machine is combinational, so the input
//   register can take a new transaction while it passes its held one.
// Reset:
//   rst_n clears the machine to disconnected, the event ring to no port,
//   and the registers to baseline 0 and recovery window 1000000 us.
// Stall:
//   While out_ch is stalled with a result held, a step in the input
//   register waits and in_ch.ready drops; port changes still pass.
module input_current_limit_ramp #(
    parameter int HISTORY_DEPTH = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    iclr_in_if.sink                           in_ch,
    iclr_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [iclr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [iclr_pkg::CFG_DAT_W-1:0]    cfg_data
);

    logic [iclr_pkg::LIMIT_W-1:0]  baseline_reg;
    logic [iclr_pkg::TIME_W-1:0]   recover_reg;

    logic                          in_full_reg;
    logic                          req_type_reg;
    logic [iclr_pkg::PORT_W-1:0]   port_id_reg;
    logic [iclr_pkg::TIME_W-1:0]   now_us_reg;
    logic                          full_chg_reg;
    logic                          vbus_sag_reg;
    logic [iclr_pkg::SUP_W-1:0]    sup_reg;

    logic                          out_valid_reg;
    iclr_pkg::iclr_result_t        out_data_reg;

    logic                          out_free;
    logic                          fire;
    logic                          fire_step;
    logic                          all_match;
    logic [iclr_pkg::LIMIT_W-1:0]  newest_limit;
    iclr_pkg::iclr_hist_ctrl_t     hist_ctrl;
    iclr_pkg::iclr_result_t        step_result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= '0;
            recover_reg  <= iclr_pkg::RECOVER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                iclr_pkg::CFG_BASELINE: baseline_reg <= cfg_data[iclr_pkg::LIMIT_W-1:0];
                iclr_pkg::CFG_RECOVER:  recover_reg  <= cfg_data[iclr_pkg::TIME_W-1:0];
            endcase
        end
    end

    // Handshake: a step needs a free output slot, a port change does not
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign fire      = in_full_reg && (req_type_reg == iclr_pkg::REQ_PORT_CHANGE || out_free);
    assign fire_step = fire && (req_type_reg == iclr_pkg::REQ_STEP);
    assign in_ch.ready = !in_full_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_full_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            req_type_reg <= in_ch.req_type;
            port_id_reg  <= in_ch.port_id;
            now_us_reg   <= in_ch.now_us;
            full_chg_reg <= in_ch.full_charging;
            vbus_sag_reg <= in_ch.vbus_sagging;
            sup_reg      <= in_ch.supplier_now;
        end
    end

    iclr_step u_step (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .req_type          (req_type_reg),
        .port_id           (port_id_reg),
        .full_charging     (full_chg_reg),
        .vbus_sagging      (vbus_sag_reg),
        .supplier_now      (sup_reg),
        .baseline_limit_ma (baseline_reg),
        .all_match         (all_match),
        .newest_limit      (newest_limit),
        .hist_ctrl         (hist_ctrl),
        .result            (step_result)
    );

    iclr_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (hist_ctrl),
        .now_us         (now_us_reg),
        .supplier_now   (sup_reg),
        .recover_max_us (recover_reg),
        .all_match      (all_match),
        .newest_limit   (newest_limit)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire_step)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.limit_ma   = out_data_reg.limit_ma;
    assign out_ch.wait_code  = out_data_reg.wait_code;
    assign out_ch.ramp_state = out_data_reg.ramp_state;

    // A held result blocks a pending step
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && req_type_reg == iclr_pkg::REQ_STEP && out_valid_reg && !out_ch.ready)
        |-> !in_ch.ready)
        else $error("step processed while output stalled");

    // Port changes never produce a result
    a_pc_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req_type_reg == iclr_pkg::REQ_PORT_CHANGE && !(out_valid_reg && !out_ch.ready))
        |=> !out_valid_reg)
        else $error("result from port change");

    // Reported ramp state is a legal code
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.ramp_state <= iclr_pkg::RS_STABLE)
        else $error("illegal ramp state");

    // A disconnected result never asks for a timed wait
    a_disc_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.ramp_state == iclr_pkg::RS_DISC)
        |-> out_data_reg.wait_code == iclr_pkg::WAIT_NONE)
        else $error("timed wait while disconnected");

endmodule

FILE: design/iclr_history.sv
// Ring of logged possible-overcurrent events and the parallel match check.
// Depends on iclr_pkg for widths, codes and the control struct.
module iclr_history #(
    parameter int HISTORY_DEPTH = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  iclr_pkg::iclr_hist_ctrl_t     ctrl,
    input  logic [iclr_pkg::TIME_W-1:0]   now_us,
    input  logic [iclr_pkg::SUP_W-1:0]    supplier_now,
    input  logic [iclr_pkg::TIME_W-1:0]   recover_max_us,
    output logic                          all_match,
    output logic [iclr_pkg::LIMIT_W-1:0]  newest_limit
);

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

    logic [PTR_W-1:0]                ptr_reg;
    logic [PTR_W-1:0]                ptr_inc;
    logic [iclr_pkg::TIME_W-1:0]     time_reg     [HISTORY_DEPTH];
    logic [iclr_pkg::TIME_W-1:0]     recovery_reg [HISTORY_DEPTH];
    logic [iclr_pkg::PORT_W-1:0]     port_reg     [HISTORY_DEPTH];
    logic [iclr_pkg::SUP_W-1:0]      sup_reg      [HISTORY_DEPTH];
    logic [iclr_pkg::LIMIT_W-1:0]    limit_reg    [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]        entry_ok;

    // Next slot, wrapping at the ring depth
    assign ptr_inc = (ptr_reg >= PTR_LAST) ? '0 : ptr_reg + 1'b1;

    // Ring storage: log on port change, recovery on the first step in detect
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                time_reg[i]     <= '0;
                recovery_reg[i] <= '0;
                port_reg[i]     <= iclr_pkg::PORT_NONE;
                sup_reg[i]      <= '0;
                limit_reg[i]    <= '0;
            end
        end
        else
        begin
            if (ctrl.log_en)
            begin
                ptr_reg            <= ptr_inc;
                time_reg[ptr_inc]  <= now_us;
                port_reg[ptr_inc]  <= ctrl.live_port;
                sup_reg[ptr_inc]   <= ctrl.live_supplier;
                limit_reg[ptr_inc] <= ctrl.live_limit;
            end
            if (ctrl.rec_en)
            begin
                recovery_reg[ptr_reg] <= now_us - time_reg[ptr_reg];
            end
        end
    end

    // Every entry must match port and supplier and have recovered quickly
    always_comb
    begin
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            entry_ok[i] = (port_reg[i] == ctrl.live_port) && (sup_reg[i] == supplier_now)
                          && (recovery_reg[i] <= recover_max_us);
        end
    end

    assign all_match    = &entry_ok;
    assign newest_limit = limit_reg[ptr_reg];

    // Pointer stays inside the ring
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_LAST)
        else $error("history pointer out of range");

    // Logging and recovery never happen on the same transaction
    a_log_rec_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.log_en && ctrl.rec_en))
        else $error("log and recovery write together");

    // A log advances the pointer by one slot
    a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.log_en |=> ptr_reg == $past(ptr_inc))
        else $error("history pointer did not advance");

endmodule

FILE: design/iclr_step.sv
// Five-state ramp machine with the live port, supplier and limit.
// Depends on iclr_pkg; drives the history ring through iclr_hist_ctrl_t.
module iclr_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic                          req_type,
    input  logic [iclr_pkg::PORT_W-1:0]   port_id,
    input  logic                          full_charging,
    input  logic                          vbus_sagging,
    input  logic [iclr_pkg::SUP_W-1:0]    supplier_now,
    input  logic [iclr_pkg::LIMIT_W-1:0]  baseline_limit_ma,
    input  logic                          all_match,
    input  logic [iclr_pkg::LIMIT_W-1:0]  newest_limit,
    output iclr_pkg::iclr_hist_ctrl_t     hist_ctrl,
    output iclr_pkg::iclr_result_t        result
);

    typedef enum logic [iclr_pkg::STATE_W-1:0] {
        ST_DISC    = iclr_pkg::RS_DISC,
        ST_DETECT  = iclr_pkg::RS_DETECT,
        ST_OCCHECK = iclr_pkg::RS_OCCHECK,
        ST_RAMP    = iclr_pkg::RS_RAMP,
        ST_STABLE  = iclr_pkg::RS_STABLE
    } mode_t;

    mode_t                         mode_reg, mode_next;
    mode_t                         last_mode_reg, last_mode_next;
    logic [iclr_pkg::PORT_W-1:0]   live_port_reg, live_port_next;
    logic [iclr_pkg::SUP_W-1:0]    live_sup_reg, live_sup_next;
    logic [iclr_pkg::LIMIT_W-1:0]  live_limit_reg, live_limit_next;
    logic [iclr_pkg::WAIT_W-1:0]   wait_code;
    logic [iclr_pkg::LIMIT_W:0]    ramp_sum;
    logic                          rec_en;
    logic                          log_en;

    assign ramp_sum = {1'b0, live_limit_reg} + {1'b0, iclr_pkg::STEP_MA};

    // One pass of the machine per transaction
    always_comb
    begin
        mode_next       = mode_reg;
        last_mode_next  = last_mode_reg;
        live_port_next  = live_port_reg;
        live_sup_next   = live_sup_reg;
        live_limit_next = live_limit_reg;
        wait_code       = iclr_pkg::WAIT_NONE;
        rec_en          = 1'b0;
        log_en          = 1'b0;
        if (fire && req_type == iclr_pkg::REQ_PORT_CHANGE)
        begin
            log_en         = (live_port_reg != iclr_pkg::PORT_NONE);
            live_port_next = port_id;
            mode_next      = (port_id == iclr_pkg::PORT_NONE) ? ST_DISC : ST_DETECT;
        end
        else if (fire)
        begin
            last_mode_next = mode_reg;
            unique case (mode_reg)
                ST_DETECT:
                begin
                    rec_en = (last_mode_reg != ST_DETECT);
                    if (full_charging)
                    begin
                        mode_next = ST_OCCHECK;
                        wait_code = iclr_pkg::WAIT_2S;
                    end
                    else
                    begin
                        wait_code = iclr_pkg::WAIT_5S;
                    end
                end
                ST_OCCHECK:
                begin
                    live_sup_next = supplier_now;
                    wait_code     = iclr_pkg::WAIT_1S;
                    if (all_match)
                    begin
                        live_limit_next = (newest_limit >= iclr_pkg::SETTLE_MA) ?
                                          newest_limit - iclr_pkg::SETTLE_MA : '0;
                        mode_next       = ST_STABLE;
                    end
                    else
                    begin
                        live_limit_next = baseline_limit_ma;
                        mode_next       = ST_RAMP;
                    end
                end
                ST_RAMP:
                begin
                    wait_code = iclr_pkg::WAIT_1S;
                    if (vbus_sagging)
                    begin
                        mode_next = ST_STABLE;
                    end
                    else if (ramp_sum > {1'b0, iclr_pkg::LIMIT_MAX})
                    begin
                        live_limit_next = iclr_pkg::LIMIT_MAX;
                    end
                    else
                    begin
                        live_limit_next = ramp_sum[iclr_pkg::LIMIT_W-1:0];
                    end
                end
                ST_DISC, ST_STABLE:
                begin
                    wait_code = iclr_pkg::WAIT_NONE;
                end
            endcase
        end
    end

    // State and live values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ST_DISC;
            last_mode_reg  <= ST_DISC;
            live_port_reg  <= iclr_pkg::PORT_NONE;
            live_sup_reg   <= '0;
            live_limit_reg <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            last_mode_reg  <= last_mode_next;
            live_port_reg  <= live_port_next;
            live_sup_reg   <= live_sup_next;
            live_limit_reg <= live_limit_next;
        end
    end

    // Controls to the history ring
    assign hist_ctrl.log_en        = log_en;
    assign hist_ctrl.rec_en        = rec_en;
    assign hist_ctrl.live_port     = live_port_reg;
    assign hist_ctrl.live_supplier = live_sup_reg;
    assign hist_ctrl.live_limit    = live_limit_reg;

    // Result of a step transaction
    assign result.limit_ma   = (mode_next == ST_RAMP || mode_next == ST_STABLE) ?
                               live_limit_next : baseline_limit_ma;
    assign result.wait_code  = wait_code;
    assign result.ramp_state = mode_next;

endmodule
